// ----- rtl/core/bayer_rggb_bilinear_demosaic_macros.svh -----
// Assertion macros for the demosaic block.
// Both sample on clk and are disabled while rst is high.
`ifndef BAYER_RGGB_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_RGGB_BILINEAR_DEMOSAIC_MACROS_SVH

// cond must hold at every edge
`define BRBD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define BRBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/brbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd_pkg
// Types, constants and helpers shared by the RGGB bilinear demosaic files.
// ----------------------------------------------------------------------------
package brbd_pkg;

  localparam int PIX_W      = 10;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int SUM_W      = PIX_W + 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(3264);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(2448);

  // 2731 / 8192 ~ 1/3, exact floor for sums up to 3 * max pixel
  localparam logic [13:0] RECIP3       = 14'd2731;
  localparam int          RECIP3_SHIFT = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLR_RED   = 2'd0,
    CLR_GREEN = 2'd1,
    CLR_BLUE  = 2'd2
  } color_t;

  typedef logic [8:0][PIX_W-1:0] window_t;

  // which window site to interpolate, and its frame position
  typedef struct packed {
    logic               row2;
    logic               col2;
    logic [COORD_W-1:0] pr;
    logic [COORD_W-1:0] pc;
  } query_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // clear bit 0, then clamp into 4..maxv
  function automatic logic [DIM_W-1:0] legal_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] e;
    e = {v[DIM_W-1:1], 1'b0};
    if (e < DIM_W'(4)) e = DIM_W'(4);
    if (e > maxv) e = {maxv[DIM_W-1:1], 1'b0};
    return e;
  endfunction

  function automatic color_t site_color(input logic rodd, input logic codd);
    if (rodd) return codd ? CLR_BLUE : CLR_GREEN;
    return codd ? CLR_GREEN : CLR_RED;
  endfunction

endpackage

// ----- rtl/core/brbd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd channel interfaces
// Raw pixel, RGB result and configuration write channels.
// ----------------------------------------------------------------------------
interface brbd_pix_if;
  logic                       valid;
  logic                       ready;
  logic [brbd_pkg::PIX_W-1:0] raw_pixel;
  modport source (output valid, raw_pixel, input ready);
  modport sink   (input valid, raw_pixel, output ready);
endinterface

interface brbd_rgb_if;
  logic                         valid;
  logic                         ready;
  logic [brbd_pkg::PIX_W-1:0]   red;
  logic [brbd_pkg::PIX_W-1:0]   green;
  logic [brbd_pkg::PIX_W-1:0]   blue;
  logic [brbd_pkg::COORD_W-1:0] out_row;
  logic [brbd_pkg::COORD_W-1:0] out_col;
  logic                         last_of_run;
  logic                         end_of_frame;
  modport source (output valid, red, green, blue, out_row, out_col, last_of_run,
                  end_of_frame, input ready);
  modport sink   (input valid, red, green, blue, out_row, out_col, last_of_run,
                  end_of_frame, output ready);
endinterface

interface brbd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [brbd_pkg::CFG_IDX_W-1:0] index;
  logic [brbd_pkg::DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/bayer_rggb_bilinear_demosaic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_rggb_bilinear_demosaic
// Streaming RGGB bilinear demosaic with two line buffers and a 3x3 window.
// ----------------------------------------------------------------------------
//  port     | dir  | transaction
//  ---------+------+---------------------------------------------
//  pixels   | sink | one raw Bayer sample, raster order
//  results  | src  | one RGB pixel with row/col, run and frame marks
//  cfg      | sink | register write (0 width, 1 height)
//
// One sample per cycle unless stalled; a sample emitting k results holds the
// input until all k are sent, limited by the single result register. Stages:
// memory read, window load, result register. rst is synchronous; line memories
// are not cleared. Output stalls back up through the window and input stage.
// ----------------------------------------------------------------------------
`include "bayer_rggb_bilinear_demosaic_macros.svh"

module bayer_rggb_bilinear_demosaic (
  input  logic         clk,
  input  logic         rst,
  brbd_pix_if.sink     pixels,
  brbd_rgb_if.source   results,
  brbd_cfg_if.sink     cfg
);

  logic [brbd_pkg::DIM_W-1:0]   width, height;
  logic [brbd_pkg::COORD_W-1:0] col_count, row_count;
  logic [brbd_pkg::DIM_W-1:0]   col_inc, row_inc;
  logic                         accept;

  logic                         s1_valid;
  logic [brbd_pkg::PIX_W-1:0]   s1_pixel;
  logic [brbd_pkg::COORD_W-1:0] s1_row, s1_col;
  logic [brbd_pkg::PIX_W-1:0]   rd_upper, rd_lower;
  logic                         s1_adv;
  logic [3:0]                   s1_mask;
  logic                         s1_last_col, s1_last_row;

  brbd_pkg::window_t            win;
  logic [3:0]                   s2_mask, pick, mask_clr;
  logic [brbd_pkg::COORD_W-1:0] s2_row, s2_col;
  logic                         issue, s2_done, out_free;
  brbd_pkg::query_t             query;
  brbd_pkg::rgb_t               rgb;

  assign cfg.ready = 1'b1;

  // config and position counters
  assign accept  = pixels.valid && pixels.ready;
  assign col_inc = {1'b0, col_count} + brbd_pkg::DIM_W'(1);
  assign row_inc = {1'b0, row_count} + brbd_pkg::DIM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= brbd_pkg::WIDTH_RESET;
      height    <= brbd_pkg::HEIGHT_RESET;
      col_count <= '0;
      row_count <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == brbd_pkg::REG_FRAME_WIDTH)
        width <= brbd_pkg::legal_dim(cfg.data, brbd_pkg::DIM_W'(brbd_pkg::MAX_WIDTH));
      else
        height <= brbd_pkg::legal_dim(cfg.data, brbd_pkg::DIM_W'(brbd_pkg::MAX_HEIGHT));
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_inc >= width) begin
        col_count <= '0;
        row_count <= (row_inc >= height) ? '0 : row_inc[brbd_pkg::COORD_W-1:0];
      end else begin
        col_count <= col_inc[brbd_pkg::COORD_W-1:0];
      end
    end
  end

  // input stage: sample plus line memory read
  assign pixels.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixels.raw_pixel;
      s1_row   <= row_count;
      s1_col   <= col_count;
    end
  end

  brbd_linebuf u_linebuf (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col_count[brbd_pkg::ADDR_W-1:0]),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col[brbd_pkg::ADDR_W-1:0]),
    .wr_pixel (s1_pixel),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower)
  );

  assign s1_last_col = ({1'b0, s1_col} + brbd_pkg::DIM_W'(1)) == width;
  assign s1_last_row = ({1'b0, s1_row} + brbd_pkg::DIM_W'(1)) == height;
  assign s1_mask[0]  = (s1_row != '0) && (s1_col != '0);
  assign s1_mask[1]  = (s1_row != '0) && s1_last_col;
  assign s1_mask[2]  = s1_last_row && (s1_col != '0);
  assign s1_mask[3]  = s1_last_row && s1_last_col;

  // window and result sequencer
  assign out_free = !results.valid || results.ready;
  assign pick     = s2_mask & (~s2_mask + 4'd1);
  assign mask_clr = s2_mask & ~pick;
  assign issue    = (s2_mask != '0) && out_free;
  assign s2_done  = (s2_mask == '0) || (issue && mask_clr == '0);
  assign s1_adv   = s1_valid && s2_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      s2_mask <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]   <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2]  <= rd_upper;
      win[5]  <= rd_lower;
      win[8]  <= s1_pixel;
      s2_mask <= s1_mask;
    end else if (issue) begin
      s2_mask <= mask_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_row <= s1_row;
      s2_col <= s1_col;
    end
  end

  assign query.row2 = pick[2] | pick[3];
  assign query.col2 = pick[1] | pick[3];
  assign query.pr   = query.row2 ? s2_row : s2_row - brbd_pkg::COORD_W'(1);
  assign query.pc   = query.col2 ? s2_col : s2_col - brbd_pkg::COORD_W'(1);

  brbd_interp u_interp (
    .win    (win),
    .query  (query),
    .width  (width),
    .height (height),
    .rgb    (rgb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (issue) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      results.red          <= rgb.red;
      results.green        <= rgb.green;
      results.blue         <= rgb.blue;
      results.out_row      <= query.pr;
      results.out_col      <= query.pc;
      results.last_of_run  <= (mask_clr == '0);
      results.end_of_frame <= pick[3];
    end
  end

  `BRBD_ASSERT_ALWAYS(a_col_in_frame, ({1'b0, col_count} < width), "column counter out of frame")
  `BRBD_ASSERT_ALWAYS(a_eof_is_last, (!results.valid || !results.end_of_frame || results.last_of_run), "frame end not last of run")
  `BRBD_ASSERT_NEXT(a_s1_hold, (s1_valid && !s1_adv), (s1_valid && $stable(s1_col) && $stable(s1_pixel)), "input stage lost a sample")

endmodule

// ----- rtl/core/brbd_linebuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd_linebuf
// Two line memories holding the previous two rows, registered read.
// ----------------------------------------------------------------------------
module brbd_linebuf (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [brbd_pkg::ADDR_W-1:0]         rd_addr,
  input  logic                                wr_en,
  input  logic [brbd_pkg::ADDR_W-1:0]         wr_addr,
  input  logic [brbd_pkg::PIX_W-1:0]          wr_pixel,
  output logic [brbd_pkg::PIX_W-1:0]          rd_upper,
  output logic [brbd_pkg::PIX_W-1:0]          rd_lower
);

  logic [brbd_pkg::PIX_W-1:0] upper_mem [brbd_pkg::MAX_WIDTH];
  logic [brbd_pkg::PIX_W-1:0] lower_mem [brbd_pkg::MAX_WIDTH];

  // rows move down one line: lower entry ages into upper
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= rd_lower;
      lower_mem[wr_addr] <= wr_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper <= upper_mem[rd_addr];
      rd_lower <= lower_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/brbd_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd_interp
// Bilinear color estimate for one window site, in-frame neighbors only.
// ----------------------------------------------------------------------------
module brbd_interp (
  input  brbd_pkg::window_t          win,
  input  brbd_pkg::query_t           query,
  input  logic [brbd_pkg::DIM_W-1:0] width,
  input  logic [brbd_pkg::DIM_W-1:0] height,
  output brbd_pkg::rgb_t             rgb
);

  function automatic logic [brbd_pkg::PIX_W-1:0] average(
      input logic [brbd_pkg::SUM_W-1:0] s, input logic [2:0] n);
    logic [brbd_pkg::SUM_W+13:0] prod;
    prod = {14'd0, s} * {{brbd_pkg::SUM_W{1'b0}}, brbd_pkg::RECIP3};
    case (n)
      3'd1:    return s[brbd_pkg::PIX_W-1:0];
      3'd2:    return s[brbd_pkg::PIX_W:1];
      3'd3:    return prod[brbd_pkg::RECIP3_SHIFT +: brbd_pkg::PIX_W];
      3'd4:    return s[brbd_pkg::PIX_W+1:2];
      default: return '0;
    endcase
  endfunction

  logic [brbd_pkg::SUM_W-1:0] sum [3];
  logic [2:0]                 cnt [3];
  logic                       top_ok, bot_ok, left_ok, right_ok;
  logic [brbd_pkg::PIX_W-1:0] center;
  logic [brbd_pkg::PIX_W-1:0] avg [3];
  brbd_pkg::color_t           own;

  assign top_ok   = query.pr != '0;
  assign left_ok  = query.pc != '0;
  assign bot_ok   = ({1'b0, query.pr} + brbd_pkg::DIM_W'(1)) < height;
  assign right_ok = ({1'b0, query.pc} + brbd_pkg::DIM_W'(1)) < width;
  assign own      = brbd_pkg::site_color(query.pr[0], query.pc[0]);
  assign center   = win[query.row2 ? (query.col2 ? 8 : 7) : (query.col2 ? 5 : 4)];

  always_comb begin
    int               ri, ci;
    logic             ok;
    brbd_pkg::color_t k;
    for (int n = 0; n < 3; n++) begin
      sum[n] = '0;
      cnt[n] = '0;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        ri = (query.row2 ? 2 : 1) + a - 1;
        ci = (query.col2 ? 2 : 1) + b - 1;
        ok = !(a == 1 && b == 1) && ri <= 2 && ci <= 2 &&
             (a != 0 || top_ok) && (a != 2 || bot_ok) &&
             (b != 0 || left_ok) && (b != 2 || right_ok);
        k = brbd_pkg::site_color(query.pr[0] ^ (a != 1), query.pc[0] ^ (b != 1));
        if (ok) begin
          sum[k] = sum[k] + {2'b00, win[(ri > 2 ? 2 : ri) * 3 + (ci > 2 ? 2 : ci)]};
          cnt[k] = cnt[k] + 3'd1;
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) avg[n] = average(sum[n], cnt[n]);
    rgb.red   = (own == brbd_pkg::CLR_RED)   ? center : avg[brbd_pkg::CLR_RED];
    rgb.green = (own == brbd_pkg::CLR_GREEN) ? center : avg[brbd_pkg::CLR_GREEN];
    rgb.blue  = (own == brbd_pkg::CLR_BLUE)  ? center : avg[brbd_pkg::CLR_BLUE];
  end

endmodule
